/* rtl/btsg_pkg.sv */
// Shared types and constants for the button tap / swipe gesture block.
// Used by btsg_cmp, btsg_div and button_tap_swipe_gesture_synth.
`default_nettype none

package btsg_pkg;

	localparam int unsigned CLICK_BIT_DEF = 0;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned COORD_W = 11;
	localparam int unsigned QUO_W   = 10;   // 650 * e / d with e < d stays below 2^10

	localparam logic [COORD_W-1:0] TOUCH_X     = 11'd960;
	localparam logic [COORD_W-1:0] TAP_Y       = 11'd540;
	localparam logic [COORD_W-1:0] SWIPE_START = 11'd850;
	localparam logic [COORD_W-1:0] SWIPE_END   = 11'd200;
	localparam logic [QUO_W-1:0]   SWIPE_SPAN  = QUO_W'(SWIPE_START - SWIPE_END);

	localparam logic [CFG_W-1:0] HOLD_RST  = 16'd250;
	localparam logic [CFG_W-1:0] TAP_RST   = 16'd100;
	localparam logic [CFG_W-1:0] SWIPE_RST = 16'd200;

	localparam logic [1:0] REG_HOLD  = 2'd0;
	localparam logic [1:0] REG_TAP   = 2'd1;
	localparam logic [1:0] REG_SWIPE = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PENDING = 3'd1,
		PH_TAP     = 3'd2,
		PH_SWIPE   = 3'd3,
		PH_WAIT    = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_CHK,
		ST_DIV,
		ST_PUT
	} ctrl_state_t;

	typedef struct packed {
		logic [15:0]       buttons_in;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        buttons_out;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
		logic               touch_active;
		logic [TIME_W-1:0]  taps_seen;
		logic [TIME_W-1:0]  swipes_seen;
	} out_item_t;

	// comparison flags of elapsed time against the three timing registers
	typedef struct packed {
		logic lt_hold;
		logic lt_tap;
		logic lt_swipe;
	} cmp_stat_t;

endpackage

`default_nettype wire

/* rtl/btsg_cmp.sv */
// Bit-serial elapsed-time unit: now - start, LSB first, with three running
// borrow chains comparing elapsed against the timing registers. Uses btsg_pkg.
`default_nettype none

module btsg_cmp
	import btsg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [TIME_W-1:0] base_ms,
	input  wire logic [CFG_W-1:0]  hold_ms,
	input  wire logic [CFG_W-1:0]  tap_ms,
	input  wire logic [CFG_W-1:0]  swipe_ms,
	output logic                   done,
	output cmp_stat_t              stat,
	output logic [CFG_W-1:0]       elapsed
);

	localparam int unsigned CNT_W = $clog2(TIME_W);

	logic [TIME_W-1:0] a_q, b_q;
	logic [CFG_W-1:0]  h_q, t_q, s_q, e_q;
	logic              bor_e_q, bor_h_q, bor_t_q, bor_s_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic eb;

	function automatic logic borrow(input logic x, input logic y, input logic bin);
		borrow = (~x & y) | (~(x ^ y) & bin);
	endfunction

	assign eb   = a_q[0] ^ b_q[0] ^ bor_e_q;
	assign done = busy_q && (cnt_q == CNT_W'(TIME_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q     <= now_ms;
			b_q     <= base_ms;
			h_q     <= hold_ms;
			t_q     <= tap_ms;
			s_q     <= swipe_ms;
			bor_e_q <= 1'b0;
			bor_h_q <= 1'b0;
			bor_t_q <= 1'b0;
			bor_s_q <= 1'b0;
		end else if (busy_q) begin
			a_q     <= {1'b0, a_q[TIME_W-1:1]};
			b_q     <= {1'b0, b_q[TIME_W-1:1]};
			h_q     <= {1'b0, h_q[CFG_W-1:1]};
			t_q     <= {1'b0, t_q[CFG_W-1:1]};
			s_q     <= {1'b0, s_q[CFG_W-1:1]};
			bor_e_q <= borrow(a_q[0], b_q[0], bor_e_q);
			bor_h_q <= borrow(eb, h_q[0], bor_h_q);
			bor_t_q <= borrow(eb, t_q[0], bor_t_q);
			bor_s_q <= borrow(eb, s_q[0], bor_s_q);
			// only the low half of elapsed is kept; the divider needs no more
			if (cnt_q < CNT_W'(CFG_W))
				e_q <= {eb, e_q[CFG_W-1:1]};
		end
	end

	assign stat.lt_hold  = bor_h_q;
	assign stat.lt_tap   = bor_t_q;
	assign stat.lt_swipe = bor_s_q;
	assign elapsed       = e_q;

endmodule

`default_nettype wire

/* rtl/btsg_div.sv */
// Serial restoring divider for swipe travel: 650 * elapsed / swipe_ms,
// one quotient bit per cycle. Uses btsg_pkg.
`default_nettype none

module btsg_div
	import btsg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CFG_W-1:0] elapsed,
	input  wire logic [CFG_W-1:0] divisor,
	output logic                  done,
	output logic [QUO_W-1:0]      quo
);

	localparam int unsigned PROD_W = CFG_W + QUO_W;
	localparam int unsigned CNT_W  = $clog2(QUO_W);

	logic [PROD_W-1:0] prod;
	logic [CFG_W-1:0]  rem_q, d_q;
	logic [QUO_W-1:0]  nb_q, quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [CFG_W:0]    trial;
	logic              ge;

	assign prod  = {{QUO_W{1'b0}}, elapsed} * {{CFG_W{1'b0}}, SWIPE_SPAN};
	assign trial = {rem_q, nb_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign done  = busy_q && (cnt_q == CNT_W'(QUO_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done)
				busy_q <= 1'b0;
		end
	end

	// elapsed < divisor, so the top part of the product is already below it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[PROD_W-1:QUO_W];
			nb_q  <= prod[QUO_W-1:0];
			d_q   <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? CFG_W'(trial - {1'b0, d_q}) : trial[CFG_W-1:0];
			nb_q  <= {nb_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

`default_nettype wire

/* rtl/button_tap_swipe_gesture_synth.sv */
// Button tap / swipe gesture synthesiser, top level.
// Depends on btsg_pkg, btsg_cmp and btsg_div.
//
// Usage: one controller report (button word, ms time stamp) enters as an
// item on in_valid/in_ready; exactly one result item leaves on
// out_valid/out_ready. Timing registers are written through cfg_we,
// cfg_idx and cfg_data (0 hold, 1 tap pulse, 2 swipe); the user must
// do so only while idle, as the block itself does not enforce it.
// Each item goes through a bit-serial elapsed-time pass (one bit of the
// 32-bit time stamp per cycle), a decision step, a division when a swipe
// position is worked out (one quotient bit per cycle) and the load of the
// output register. One item is processed at a time and the input is taken
// only in the idle state, so a new item waits until the last one is put out.
// The output register frees the input side: a new item may be taken while
// the last result waits, but a finished result is held until out_ready,
// stalling the next one at its final cycle.
// Reset puts the gesture in idle, clears time base and counters and
// restores the default timing values; no clearing pass is needed.
`default_nettype none

module button_tap_swipe_gesture_synth
	import btsg_pkg::*;
#(
	parameter int unsigned CLICK_BIT = CLICK_BIT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_item,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_data
);

	ctrl_state_t state_q, state_n;
	phase_t      phase_q, phase_n;

	logic [CFG_W-1:0]  hold_q, tap_q, swipe_q;
	logic [TIME_W-1:0] start_q, taps_q, swipes_q;
	in_item_t          item_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              cmp_start, cmp_done, div_start, div_done, put;
	cmp_stat_t         stat;
	logic [CFG_W-1:0]  elapsed;
	logic [QUO_W-1:0]  quo;

	logic               pressed, tap, swipe, load_start, tap_inc, swipe_inc;
	logic [COORD_W-1:0] sy;
	out_item_t          res;

	btsg_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmp_start),
		.now_ms   (item_q.now_ms),
		.base_ms  (start_q),
		.hold_ms  (hold_q),
		.tap_ms   (tap_q),
		.swipe_ms (swipe_q),
		.done     (cmp_done),
		.stat     (stat),
		.elapsed  (elapsed)
	);

	btsg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.elapsed (elapsed),
		.divisor (swipe_q),
		.done    (div_done),
		.quo     (quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		put       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_n = ST_CMP;
			end
			ST_CMP: begin
				// start pulses on entry; unit then runs until done
				if (cmp_done)
					state_n = ST_CHK;
			end
			ST_CHK: begin
				if (phase_q == PH_SWIPE && stat.lt_swipe) begin
					div_start = 1'b1;
					state_n   = ST_DIV;
				end else begin
					state_n = ST_PUT;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_n = ST_PUT;
			end
			ST_PUT: begin
				if (!out_valid_q || out_ready) begin
					put     = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// kick the serial pass the cycle after the item is captured
	logic cmp_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmp_go_q <= 1'b0;
		else
			cmp_go_q <= in_valid && in_ready;
	end
	assign cmp_start = cmp_go_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_item;
	end

	// gesture decision
	assign pressed = item_q.buttons_in[CLICK_BIT];

	always_comb begin
		phase_n    = phase_q;
		load_start = 1'b0;
		tap_inc    = 1'b0;
		swipe_inc  = 1'b0;
		tap        = 1'b0;
		swipe      = 1'b0;
		sy         = '0;
		case (phase_q)
			PH_PENDING: begin
				if (!pressed) begin
					phase_n    = PH_TAP;
					load_start = 1'b1;
					tap_inc    = 1'b1;
					tap        = 1'b1;
				end else if (!stat.lt_hold) begin
					phase_n    = PH_SWIPE;
					load_start = 1'b1;
					swipe_inc  = 1'b1;
					swipe      = 1'b1;
					sy         = SWIPE_START;
				end
			end
			PH_TAP: begin
				if (stat.lt_tap) begin
					tap = 1'b1;
				end else if (pressed) begin
					phase_n    = PH_PENDING;
					load_start = 1'b1;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_SWIPE: begin
				if (stat.lt_swipe) begin
					swipe = 1'b1;
					sy    = SWIPE_START - {{(COORD_W - QUO_W){1'b0}}, quo};
				end else begin
					phase_n = pressed ? PH_WAIT : PH_IDLE;
				end
			end
			PH_WAIT: begin
				if (!pressed)
					phase_n = PH_IDLE;
			end
			default: begin
				phase_n = PH_IDLE;
				if (pressed) begin
					phase_n    = PH_PENDING;
					load_start = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		res                        = '0;
		res.buttons_out            = item_q.buttons_in;
		res.buttons_out[CLICK_BIT] = tap;
		if (tap) begin
			res.touch_x      = TOUCH_X;
			res.touch_y      = TAP_Y;
			res.touch_active = 1'b1;
		end else if (swipe) begin
			res.touch_x      = TOUCH_X;
			res.touch_y      = sy;
			res.touch_active = 1'b1;
		end
		res.taps_seen   = taps_q + {{(TIME_W - 1){1'b0}}, tap_inc};
		res.swipes_seen = swipes_q + {{(TIME_W - 1){1'b0}}, swipe_inc};
	end

	// gesture state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			start_q  <= '0;
			taps_q   <= '0;
			swipes_q <= '0;
		end else if (put) begin
			phase_q  <= phase_n;
			taps_q   <= res.taps_seen;
			swipes_q <= res.swipes_seen;
			if (load_start)
				start_q <= item_q.now_ms;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RST;
			tap_q   <= TAP_RST;
			swipe_q <= SWIPE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HOLD:  hold_q  <= cfg_data;
				REG_TAP:   tap_q   <= cfg_data;
				REG_SWIPE: swipe_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (put)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (put)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire
